[src/khm_pkg.sv]
// khm_pkg: shared constants for the k-way heap merge core
// no dependencies; used by k_way_heap_merge_core for field widths and defaults

package khm_pkg;

    // default sizing of the merge core
    localparam int DEF_MAX_LISTS  = 16;
    localparam int DEF_VALUE_BITS = 32;

    // fixed field widths
    localparam int LIST_BITS = 4;
    localparam int CFG_BITS  = 5;

    // lists_in_use after reset
    localparam logic [CFG_BITS-1:0] CFG_RESET = 5'd16;

endpackage

[src/khm_ram.sv]
// khm_ram: generic single-write, single-read synchronous ram with registered read
// no dependencies; holds the heap entries of the merge core

module khm_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/k_way_heap_merge_core.sv]
// k_way_heap_merge_core: merges descending lists through a binary max-heap of list heads
// depends on khm_pkg (widths, defaults) and khm_ram (heap entry storage)
//
//  channel   | dir | handshake           | payload
//  ----------+-----+---------------------+---------------------------------------------
//  s_        | in  | s_tvalid / s_tready | tdata: value, list_index; tuser: exhausted
//  m_        | out | m_tvalid / m_tready | tdata: merged_value, source_list; tlast: last
//  cfg_      | in  | cfg_we              | cfg_wdata: lists_in_use
//
// one beat at a time: an accept step, a read and a compare step per parent on sift-up,
// a final write when the element settles at the root, then a decide step; an extract adds
// root and last-entry fetch steps, a left-read, right-read and compare step per sift-down
// level, a final write when the hole ends without children and an emit step; the heap ram
// has one read and one write port with registered read, which sets this sequence of steps.
// aresetn clears control state and the heap count; ram contents are not cleared.
// a finished result waits in the output register; the next beat is taken meanwhile,
// and the core only holds in its emit step while that register is full and m_tready is low.

module k_way_heap_merge_core #(
    parameter int MAX_LISTS  = khm_pkg::DEF_MAX_LISTS,
    parameter int VALUE_BITS = khm_pkg::DEF_VALUE_BITS,
    localparam int LB = khm_pkg::LIST_BITS,
    localparam int DW = ((VALUE_BITS + LB + 7) / 8) * 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration
    input  logic                         cfg_we,
    input  logic [khm_pkg::CFG_BITS-1:0] cfg_wdata,   // lists_in_use
    // input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [DW-1:0]                s_tdata,     // value, list_index
    input  logic                         s_tuser,     // exhausted
    // result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [DW-1:0]                m_tdata,     // merged_value, source_list
    output logic                         m_tlast      // last
);

    localparam int AW      = $clog2(MAX_LISTS);
    localparam int CW      = $clog2(MAX_LISTS + 1);
    localparam int CI      = AW + 2;
    localparam int ENT_W   = VALUE_BITS + LB;
    localparam int EFF_MAX = (MAX_LISTS < 31) ? MAX_LISTS : 31;
    localparam int EW      = $clog2(EFF_MAX + 1);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_UP_RD  = 4'd1;
    localparam logic [3:0] ST_UP_CMP = 4'd2;
    localparam logic [3:0] ST_UP_FIN = 4'd3;
    localparam logic [3:0] ST_DECIDE = 4'd4;
    localparam logic [3:0] ST_X_TOP  = 4'd5;
    localparam logic [3:0] ST_X_LST  = 4'd6;
    localparam logic [3:0] ST_DN_L   = 4'd7;
    localparam logic [3:0] ST_DN_R   = 4'd8;
    localparam logic [3:0] ST_DN_C   = 4'd9;
    localparam logic [3:0] ST_EMIT   = 4'd10;

    // heap entry: list in the upper bits, value in the lower
    typedef logic [ENT_W-1:0] entry_t;

    // true when entry a leaves the heap before entry b
    function automatic logic outranks(input entry_t a, input entry_t b);
        logic signed [VALUE_BITS-1:0] va;
        logic signed [VALUE_BITS-1:0] vb;
        va = a[VALUE_BITS-1:0];
        vb = b[VALUE_BITS-1:0];
        if (va != vb) begin
            return va > vb;
        end
        return a[ENT_W-1:VALUE_BITS] < b[ENT_W-1:VALUE_BITS];
    endfunction

    logic [3:0]                   state_reg, state_next;
    logic [khm_pkg::CFG_BITS-1:0] lists_reg;
    logic [CW-1:0]                count_reg, count_next;
    logic [EW-1:0]                heads_reg, heads_next;
    logic [AW-1:0]                pos_reg, pos_next;
    entry_t                       elem_reg, elem_next;
    entry_t                       top_reg, top_next;
    entry_t                       lchild_reg, lchild_next;
    logic                         hold_reg, hold_next;
    logic                         last_reg, last_next;
    logic                         m_valid_reg;
    entry_t                       m_data_reg;
    logic                         m_last_reg;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    entry_t                       ram_wdata;
    logic [AW-1:0]                ram_raddr;
    entry_t                       ram_rdata;

    logic                         accept;
    logic [EW-1:0]                eff;
    logic [AW-1:0]                parent;
    logic [CI-1:0]                left_idx, right_idx;
    logic                         left_ok, right_ok;
    logic                         emit_go;
    entry_t                       in_entry;

    khm_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_LISTS)
    ) u_heap_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_entry = {s_tdata[VALUE_BITS +: LB], s_tdata[VALUE_BITS-1:0]};
    assign emit_go  = !m_valid_reg || m_tready;

    // effective list count, clamped to 1..min(MAX_LISTS, 31)
    always_comb begin
        if (lists_reg == '0) begin
            eff = EW'(1);
        end else if (lists_reg > khm_pkg::CFG_BITS'(EFF_MAX)) begin
            eff = EW'(EFF_MAX);
        end else begin
            eff = EW'(lists_reg);
        end
    end

    // heap index arithmetic
    assign parent    = AW'((pos_reg - AW'(1)) >> 1);
    assign left_idx  = {1'b0, pos_reg, 1'b1};
    assign right_idx = left_idx + CI'(1);
    assign left_ok   = left_idx < CI'(count_reg);
    assign right_ok  = right_idx < CI'(count_reg);

    // sequencer: insert with sift-up; once filled, extract with sift-down
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        heads_next  = heads_reg;
        pos_next    = pos_reg;
        elem_next   = elem_reg;
        top_next    = top_reg;
        lchild_next = lchild_reg;
        hold_next   = hold_reg;
        last_next   = last_reg;
        ram_we      = 1'b0;
        ram_waddr   = pos_reg;
        ram_wdata   = elem_reg;
        ram_raddr   = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    elem_next = in_entry;
                    // fill bookkeeping
                    if (heads_reg < eff) begin
                        heads_next = heads_reg + EW'(1);
                        hold_next  = (heads_reg + EW'(1)) < eff;
                    end else begin
                        hold_next = 1'b0;
                    end
                    // insert unless exhausted or heap full
                    if (!s_tuser && (count_reg < CW'(MAX_LISTS))) begin
                        pos_next   = AW'(count_reg);
                        count_next = count_reg + CW'(1);
                        state_next = (count_reg == '0) ? ST_UP_FIN : ST_UP_RD;
                    end else begin
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_UP_RD: begin
                ram_raddr  = parent;
                state_next = ST_UP_CMP;
            end
            ST_UP_CMP: begin
                ram_we = 1'b1;
                if (outranks(elem_reg, ram_rdata)) begin
                    // move the parent down into the hole
                    ram_wdata  = ram_rdata;
                    pos_next   = parent;
                    state_next = (parent == '0) ? ST_UP_FIN : ST_UP_RD;
                end else begin
                    state_next = ST_DECIDE;
                end
            end
            ST_UP_FIN: begin
                ram_we     = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                ram_raddr = '0;
                if (hold_reg) begin
                    state_next = ST_IDLE;
                end else if (count_reg == '0) begin
                    heads_next = '0;
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_X_TOP;
                end
            end
            ST_X_TOP: begin
                // root arrives; fetch the last entry
                top_next   = ram_rdata;
                ram_raddr  = AW'(count_reg - CW'(1));
                count_next = count_reg - CW'(1);
                state_next = ST_X_LST;
            end
            ST_X_LST: begin
                elem_next = ram_rdata;
                pos_next  = '0;
                if (count_reg == '0) begin
                    last_next  = 1'b1;
                    heads_next = '0;
                    state_next = ST_EMIT;
                end else begin
                    last_next  = 1'b0;
                    state_next = ST_DN_L;
                end
            end
            ST_DN_L: begin
                if (!left_ok) begin
                    ram_we     = 1'b1;
                    state_next = ST_EMIT;
                end else begin
                    ram_raddr  = left_idx[AW-1:0];
                    state_next = ST_DN_R;
                end
            end
            ST_DN_R: begin
                lchild_next = ram_rdata;
                ram_raddr   = right_ok ? right_idx[AW-1:0] : left_idx[AW-1:0];
                state_next  = ST_DN_C;
            end
            ST_DN_C: begin
                ram_we = 1'b1;
                // pick the best of hole element, left and right child
                if (right_ok && outranks(ram_rdata, elem_reg)
                        && !outranks(lchild_reg, elem_reg)) begin
                    ram_wdata  = ram_rdata;
                    pos_next   = right_idx[AW-1:0];
                    state_next = ST_DN_L;
                end else if (outranks(lchild_reg, elem_reg)) begin
                    if (right_ok && outranks(ram_rdata, lchild_reg)) begin
                        ram_wdata = ram_rdata;
                        pos_next  = right_idx[AW-1:0];
                    end else begin
                        ram_wdata = lchild_reg;
                        pos_next  = left_idx[AW-1:0];
                    end
                    state_next = ST_DN_L;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            heads_reg   <= '0;
            lists_reg   <= khm_pkg::CFG_RESET;
            m_valid_reg <= 1'b0;
            hold_reg    <= 1'b0;
            last_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            heads_reg <= heads_next;
            hold_reg  <= hold_next;
            last_reg  <= last_next;
            if (cfg_we) begin
                lists_reg <= cfg_wdata;
            end
            if (state_reg == ST_EMIT && emit_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // working payload and output register
    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        elem_reg   <= elem_next;
        top_reg    <= top_next;
        lchild_reg <= lchild_next;
        if (state_reg == ST_EMIT && emit_go) begin
            m_data_reg <= top_reg;
            m_last_reg <= last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = DW'(m_data_reg);
    assign m_tlast  = m_last_reg;

endmodule
